// ----- src/uer_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared widths, phase and register codes, reset values and the structs
// that pass between the blocks of the ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    // Field widths of the channels and registers.
    localparam int TRIG_W      = 8;
    localparam int TIMEOUT_W   = 24;
    localparam int SCALE_W     = 16;
    localparam int DIST_W      = 16;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;

    // Measurement phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_MEAS = 2'd3;

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_TICKS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CM_PER_TICK_Q16 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISTANCE_CM = 2'd3;

    // Register reset values.
    localparam logic [TRIG_W-1:0]    RST_TRIGGER_TICKS   = 8'd4;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_TICKS   = 24'd5888;
    localparam logic [SCALE_W-1:0]   RST_CM_PER_TICK_Q16 = 16'd4496;
    localparam logic [DIST_W-1:0]    RST_MAX_DISTANCE_CM = 16'd400;

    // Configuration register set.
    typedef struct packed {
        logic [TRIG_W-1:0]    trigger_ticks;
        logic [TIMEOUT_W-1:0] timeout_ticks;
        logic [SCALE_W-1:0]   cm_per_tick_q16;
        logic [DIST_W-1:0]    max_distance_cm;
    } cfg_t;

    // Outcome of one tick, handed from the controller to the result stage.
    typedef struct packed {
        logic [1:0] phase;
        logic       meas_done;
        logic       tmo_done;
    } step_t;

endpackage

// ----- src/uer_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger channel interfaces
// Valid/ready channels for timer ticks, results and register writes.
// ----------------------------------------------------------------------------

// One beat per prescaled timer tick.
interface uer_in_if;
    import uer_pkg::*;

    logic valid;
    logic ready;
    logic start_req;
    logic echo;

    modport source (output valid, output start_req, output echo, input ready);
    modport sink (input valid, input start_req, input echo, output ready);
endinterface

// One result beat per tick.
interface uer_out_if;
    import uer_pkg::*;

    logic              valid;
    logic              ready;
    logic              trig_out;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic [DIST_W-1:0] distance_cm;

    modport source (
        output valid, output trig_out, output busy_res, output done_res,
        output timed_out, output distance_cm, input ready
    );
    modport sink (
        input valid, input trig_out, input busy_res, input done_res,
        input timed_out, input distance_cm, output ready
    );
endinterface

// Register write channel.
interface uer_cfg_if;
    import uer_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/uer_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger configuration registers
// Takes register write beats and holds the four settings.
// ----------------------------------------------------------------------------
module uer_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    uer_cfg_if.sink       cfg,
    output uer_pkg::cfg_t cfg_q
);
    import uer_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    // Decode the register index and mask the data to the register width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TRIGGER_TICKS:   cfg_next.trigger_ticks   = cfg.data[TRIG_W-1:0];
                REG_TIMEOUT_TICKS:   cfg_next.timeout_ticks   = cfg.data[TIMEOUT_W-1:0];
                REG_CM_PER_TICK_Q16: cfg_next.cm_per_tick_q16 = cfg.data[SCALE_W-1:0];
                REG_MAX_DISTANCE_CM: cfg_next.max_distance_cm = cfg.data[DIST_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks   <= RST_TRIGGER_TICKS;
            cfg_reg.timeout_ticks   <= RST_TIMEOUT_TICKS;
            cfg_reg.cm_per_tick_q16 <= RST_CM_PER_TICK_Q16;
            cfg_reg.max_distance_cm <= RST_MAX_DISTANCE_CM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/uer_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger controller
// Registers each tick, steps the trigger/wait/measure sequencer and
// registers the tick count times the scale for the result stage.
// ----------------------------------------------------------------------------
module uer_ctrl #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    uer_in_if.sink                                 tick,
    input  uer_pkg::cfg_t                          cfg_q,
    input  logic                                   out_can_take,
    output logic                                   s2_valid,
    output uer_pkg::step_t                         s2_step,
    output logic [COUNT_WIDTH+uer_pkg::SCALE_W-1:0] s2_product
);
    import uer_pkg::*;

    localparam int CMP_W  = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
    localparam int PROD_W = COUNT_WIDTH + SCALE_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Input register.
    logic s1_valid_reg;
    logic s1_start_reg;
    logic s1_echo_reg;

    // Sequencer state.
    logic [1:0]             phase_reg;
    logic [1:0]             phase_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   prev_echo_reg;

    // Stage two register.
    logic              s2_valid_reg;
    step_t             s2_step_reg;
    step_t             step_next;
    logic [PROD_W-1:0] product_reg;

    logic                   s2_free;
    logic                   s1_move;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   expired;
    logic                   rising;
    logic                   falling;

    // Handshake between the stages.
    assign s2_free    = !s2_valid_reg || out_can_take;
    assign s1_move    = s1_valid_reg && s2_free;
    assign tick.ready = !s1_valid_reg || s2_free;

    assign s2_valid   = s2_valid_reg;
    assign s2_step    = s2_step_reg;
    assign s2_product = product_reg;

    // Saturating increment, timeout test and edge detection.
    assign cnt_inc = (count_reg == CNT_MAX) ? CNT_MAX : count_reg + COUNT_WIDTH'(1);
    assign expired = (CMP_W'(cnt_inc) > CMP_W'(cfg_q.timeout_ticks)) || (cnt_inc == CNT_MAX);
    assign rising  = s1_echo_reg && !prev_echo_reg;
    assign falling = !s1_echo_reg && prev_echo_reg;

    // Sequencer next state.
    always_comb
    begin
        phase_next          = phase_reg;
        count_next          = count_reg;
        step_next.meas_done = 1'b0;
        step_next.tmo_done  = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (s1_start_reg)
                begin
                    phase_next = PH_TRIG;
                    count_next = COUNT_WIDTH'(1);
                end
            end
            PH_TRIG:
            begin
                if (count_reg >= COUNT_WIDTH'(cfg_q.trigger_ticks))
                begin
                    phase_next = PH_WAIT;
                    count_next = '0;
                end
                else
                begin
                    count_next = cnt_inc;
                end
            end
            PH_WAIT:
            begin
                if (rising)
                begin
                    phase_next = PH_MEAS;
                    count_next = '0;
                end
                else if (expired)
                begin
                    phase_next         = PH_IDLE;
                    count_next         = '0;
                    step_next.tmo_done = 1'b1;
                end
                else
                begin
                    count_next = cnt_inc;
                end
            end
            PH_MEAS:
            begin
                if (falling)
                begin
                    phase_next          = PH_IDLE;
                    count_next          = '0;
                    step_next.meas_done = 1'b1;
                end
                else if (expired)
                begin
                    phase_next         = PH_IDLE;
                    count_next         = '0;
                    step_next.tmo_done = 1'b1;
                end
                else
                begin
                    count_next = cnt_inc;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                count_next = '0;
            end
        endcase
        step_next.phase = phase_next;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            s1_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            s1_start_reg <= tick.start_req;
            s1_echo_reg  <= tick.echo;
        end
    end

    // Sequencer state advances once per tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            prev_echo_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            prev_echo_reg <= s1_echo_reg;
        end
    end

    // Stage two: tick outcome and scaled count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_step_reg <= step_next;
            product_reg <= PROD_W'(cnt_inc) * PROD_W'(cfg_q.cm_per_tick_q16);
        end
    end

endmodule

// ----- src/uer_result.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger result stage
// Drops the fraction, clamps the distance, keeps the held distance and
// timeout flag, and drives the result register.
// ----------------------------------------------------------------------------
module uer_result #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  uer_pkg::cfg_t                           cfg_q,
    input  logic                                    s2_valid,
    input  uer_pkg::step_t                          s2_step,
    input  logic [COUNT_WIDTH+uer_pkg::SCALE_W-1:0] s2_product,
    output logic                                    out_can_take,
    uer_out_if.source                               result
);
    import uer_pkg::*;

    logic              valid_reg;
    logic              trig_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              tmo_flag_reg;
    logic              tmo_flag_next;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;
    logic              s2_move;

    logic [COUNT_WIDTH-1:0] scaled;

    assign out_can_take = !valid_reg || result.ready;
    assign s2_move      = s2_valid && out_can_take;

    // Integer centimetres, clamped to the configured maximum.
    assign scaled = s2_product[COUNT_WIDTH+SCALE_W-1:SCALE_W];

    always_comb
    begin
        dist_next     = dist_reg;
        tmo_flag_next = tmo_flag_reg;
        if (s2_step.tmo_done)
        begin
            dist_next     = cfg_q.max_distance_cm;
            tmo_flag_next = 1'b1;
        end
        else if (s2_step.meas_done)
        begin
            tmo_flag_next = 1'b0;
            if (scaled > COUNT_WIDTH'(cfg_q.max_distance_cm))
            begin
                dist_next = cfg_q.max_distance_cm;
            end
            else
            begin
                dist_next = scaled[DIST_W-1:0];
            end
        end
    end

    // Result register; distance and flag are held between measurements.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            trig_reg     <= 1'b0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            tmo_flag_reg <= 1'b0;
            dist_reg     <= '0;
        end
        else
        begin
            if (out_can_take)
            begin
                valid_reg <= s2_valid;
            end
            if (s2_move)
            begin
                trig_reg     <= (s2_step.phase == PH_TRIG);
                busy_reg     <= (s2_step.phase != PH_IDLE);
                done_reg     <= s2_step.meas_done || s2_step.tmo_done;
                tmo_flag_reg <= tmo_flag_next;
                dist_reg     <= dist_next;
            end
        end
    end

    assign result.valid       = valid_reg;
    assign result.trig_out    = trig_reg;
    assign result.busy_res    = busy_reg;
    assign result.done_res    = done_reg;
    assign result.timed_out   = tmo_flag_reg;
    assign result.distance_cm = dist_reg;

endmodule

// ----- src/ultrasonic_echo_ranger.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Echo-pulse rangefinder driven one prescaled timer tick at a time.
// ----------------------------------------------------------------------------
// Usage:
//   tick   - one beat per timer tick with start_req and the sampled echo level.
//   result - one beat per tick: trigger drive, busy, done, timeout flag and
//            the held distance in centimetres.
//   cfg    - register writes (index, data); always ready. Write only while
//            the ranger is idle and no tick beat is still in flight.
// Throughput: one tick beat per cycle while result.ready is high. The
//   sequencer steps phase and count from the input register, so each tick
//   sees the previous one.
// Pipeline: input, count-times-scale multiplier and result registers.
// Stalls: the stages hold while result.ready is low; tick.ready drops only
//   once all three stages are full.
// Reset: rst_n clears the pipeline, returns to idle with a zero count and
//   zero distance, and loads the default register values.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    uer_in_if.sink    tick,
    uer_out_if.source result,
    uer_cfg_if.sink   cfg
);
    import uer_pkg::*;

    cfg_t                            cfg_q;
    logic                            out_can_take;
    logic                            s2_valid;
    step_t                           s2_step;
    logic [COUNT_WIDTH+SCALE_W-1:0]  s2_product;

    // Configuration registers.
    uer_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // Tick sequencer and multiplier stage.
    uer_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .cfg_q        (cfg_q),
        .out_can_take (out_can_take),
        .s2_valid     (s2_valid),
        .s2_step      (s2_step),
        .s2_product   (s2_product)
    );

    // Clamp and result register.
    uer_result #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_q        (cfg_q),
        .s2_valid     (s2_valid),
        .s2_step      (s2_step),
        .s2_product   (s2_product),
        .out_can_take (out_can_take),
        .result       (result)
    );

endmodule
